/* rtl/u8d_pkg.sv */
// Shared types and constants for the UTF-8 byte stream decoder.
package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 31;
    localparam int REM_W  = 3;
    localparam int ERR_W  = 32;
    localparam int CONT_W = 6;

    // Lead byte patterns, matched with wildcards
    localparam logic [BYTE_W-1:0] LEAD_1B = 8'b0???????;
    localparam logic [BYTE_W-1:0] LEAD_2B = 8'b110?????;
    localparam logic [BYTE_W-1:0] LEAD_3B = 8'b1110????;
    localparam logic [BYTE_W-1:0] LEAD_4B = 8'b11110???;
    localparam logic [BYTE_W-1:0] LEAD_5B = 8'b111110??;
    localparam logic [BYTE_W-1:0] LEAD_6B = 8'b1111110?;

    // Continuation bytes still expected after each lead form
    localparam logic [REM_W-1:0] REM_2B = 3'd1;
    localparam logic [REM_W-1:0] REM_3B = 3'd2;
    localparam logic [REM_W-1:0] REM_4B = 3'd3;
    localparam logic [REM_W-1:0] REM_5B = 3'd4;
    localparam logic [REM_W-1:0] REM_6B = 3'd5;
    localparam logic [REM_W-1:0] REM_MAX = REM_6B;

    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              stream_end;
    } t_in_item;

    typedef struct packed {
        logic              code_valid;
        logic [CP_W-1:0]   code_point;
        logic              error_now;
        logic [ERR_W-1:0]  error_total;
    } t_out_item;

    typedef struct packed {
        logic [CP_W-1:0]   partial_code;
        logic [REM_W-1:0]  bytes_remaining;
        logic [ERR_W-1:0]  error_counter;
    } t_dec_state;

endpackage

/* rtl/u8d_stream_if.sv */
// Valid/ready stream interface carrying one item of payload type T.
interface u8d_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/u8d_step.sv */
// Combinational decode of one byte against the current decoder state.
module u8d_step (
    input  u8d_pkg::t_dec_state i_state,
    input  u8d_pkg::t_in_item   i_item,
    output u8d_pkg::t_dec_state o_state,
    output u8d_pkg::t_out_item  o_result
);
    logic [u8d_pkg::BYTE_W-1:0] w_b;
    logic                       w_err;
    logic [u8d_pkg::ERR_W-1:0]  w_cnt;
    logic [u8d_pkg::CP_W-1:0]   w_shifted;
    logic                       w_code_valid;
    logic [u8d_pkg::CP_W-1:0]   w_code_point;
    u8d_pkg::t_dec_state        w_upd;

    assign w_b = i_item.data_byte;
    assign w_shifted = {i_state.partial_code[u8d_pkg::CP_W-u8d_pkg::CONT_W-1:0],
                        w_b[u8d_pkg::CONT_W-1:0]};

    // Decode lead or continuation byte
    always_comb begin
        w_upd        = i_state;
        w_err        = 1'b0;
        w_code_valid = 1'b0;
        w_code_point = '0;
        if (i_state.bytes_remaining == '0) begin
            case (w_b) inside
                u8d_pkg::LEAD_1B: begin
                    w_code_valid = 1'b1;
                    w_code_point = u8d_pkg::CP_W'(w_b);
                end
                u8d_pkg::LEAD_2B: begin
                    w_upd.partial_code    = u8d_pkg::CP_W'(w_b[4:0]);
                    w_upd.bytes_remaining = u8d_pkg::REM_2B;
                end
                u8d_pkg::LEAD_3B: begin
                    w_upd.partial_code    = u8d_pkg::CP_W'(w_b[3:0]);
                    w_upd.bytes_remaining = u8d_pkg::REM_3B;
                end
                u8d_pkg::LEAD_4B: begin
                    w_upd.partial_code    = u8d_pkg::CP_W'(w_b[2:0]);
                    w_upd.bytes_remaining = u8d_pkg::REM_4B;
                end
                u8d_pkg::LEAD_5B: begin
                    w_upd.partial_code    = u8d_pkg::CP_W'(w_b[1:0]);
                    w_upd.bytes_remaining = u8d_pkg::REM_5B;
                end
                u8d_pkg::LEAD_6B: begin
                    w_upd.partial_code    = u8d_pkg::CP_W'(w_b[0]);
                    w_upd.bytes_remaining = u8d_pkg::REM_6B;
                end
                default: begin
                    w_err = 1'b1;
                end
            endcase
        end else if (w_b[7:6] == u8d_pkg::CONT_TAG) begin
            w_upd.bytes_remaining = i_state.bytes_remaining - 3'd1;
            if (i_state.bytes_remaining == 3'd1) begin
                w_code_valid       = 1'b1;
                w_code_point       = w_shifted;
                w_upd.partial_code = '0;
            end else begin
                w_upd.partial_code = w_shifted;
            end
        end else begin
            // abandon the open sequence, the byte is consumed
            w_err                 = 1'b1;
            w_upd.partial_code    = '0;
            w_upd.bytes_remaining = '0;
        end
    end

    // Saturating error count
    always_comb begin
        w_cnt = i_state.error_counter;
        if (w_err && (i_state.error_counter != '1)) begin
            w_cnt = i_state.error_counter + 32'd1;
        end
    end

    assign o_result = {w_code_valid, w_code_point, w_err, w_cnt};

    // Clear everything after the stream's last byte
    always_comb begin
        o_state               = w_upd;
        o_state.error_counter = w_cnt;
        if (i_item.stream_end) begin
            o_state = '0;
        end
    end
endmodule

/* rtl/utf8_byte_stream_decoder_top.sv */
// Top level of the UTF-8 byte stream decoder with input and result registers.
// Decodes one UTF-8 byte per item (legacy 5- and 6-byte leads included, no
// overlong check) and returns exactly one result per byte: a code point when
// the byte completes one, an error flag for a bad lead or continuation byte,
// and the saturating error count of the current stream. An item marked
// stream_end drops any open sequence and clears the count after its result.
// Throughput is one item per cycle while o_out is ready. An accepted item passes
// through the input register, then the result register, with the decoder
// state updated in the single logic pass between them.
module utf8_byte_stream_decoder_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8d_stream_if.sink    i_in,
    u8d_stream_if.source  o_out
);
    logic                 r_in_valid;
    u8d_pkg::t_in_item    r_in_item;
    logic                 r_out_valid;
    u8d_pkg::t_out_item   r_out_item;
    u8d_pkg::t_dec_state  r_state;
    u8d_pkg::t_dec_state  n_state;
    u8d_pkg::t_out_item   n_out_item;
    logic                 w_adv;

    // Move the held byte into the result register when that is free
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    u8d_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    // Control and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.payload;
        end
        if (w_adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

    // No result both completes a code point and flags an error
    a_valid_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_item.code_valid && r_out_item.error_now))
        else $error("code_valid and error_now both set");

    // State clears after the last byte of a stream
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_item.stream_end) |=> (r_state == '0))
        else $error("state not cleared after stream end");

    // Never more than five continuation bytes pending
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_remaining <= u8d_pkg::REM_MAX)
        else $error("bytes_remaining out of range");

    // A held input byte is not overwritten before it is decoded
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_item)))
        else $error("held input byte lost");
endmodule
